// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define JCFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define JCFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// jcfe_pkg
// types, character constants and helpers of the content field extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jcfe_pkg;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_COLON  = 3'd1,
		PH_SPACE  = 3'd2,
		PH_STRING = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_KEY   = 2'd1,
		ST_NO_COLON = 2'd2,
		ST_NO_QUOTE = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       finished;
		status_t    status;
	} res_item_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

	localparam int unsigned KEY_LEN = 9;
	localparam logic [8*KEY_LEN-1:0] KEY = "\"content\"";

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;

	function automatic logic is_live(input phase_t ph);
		return (ph == PH_SEARCH) || (ph == PH_COLON) || (ph == PH_SPACE) ||
			(ph == PH_STRING);
	endfunction

	function automatic status_t end_status(input phase_t ph);
		status_t st;
		unique case (ph)
			PH_SEARCH: st = ST_NO_KEY;
			PH_COLON:  st = ST_NO_COLON;
			PH_SPACE:  st = ST_NO_QUOTE;
			default:   st = ST_OK;
		endcase
		return st;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/jcfe_window.sv =====
// ----------------------------------------------------------------------------
// jcfe_window
// sliding byte window and key compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jcfe_window import jcfe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire win_ctrl_t  ctrl,
	input  wire logic [7:0] in_char,
	output logic            hit
);

	localparam int unsigned WIN_W = 8 * (KEY_LEN - 1);

	// oldest byte in the top bits, newest in the bottom
	logic [WIN_W-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= {win_q[WIN_W-9:0], in_char};
		end
	end

	// key seen when the current byte completes it, before that byte is shifted in
	assign hit = ({win_q, in_char} == KEY);

endmodule

`default_nettype wire

// ===== rtl/jcfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// jcfe_ctrl
// extraction phase machine, unescaping and result build
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jcfe_ctrl import jcfe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire logic     hit,
	output win_ctrl_t     win,
	output res_item_t     res,
	output logic          res_valid
);

`include "assert_macros.svh"

	phase_t phase_q;
	phase_t phase_d;
	logic   esc_q;
	logic   esc_d;
	logic   [7:0] c;

	assign c = item.in_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			esc_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		res     = '0;
		win     = '0;
		if (step) begin
			if (is_live(phase_q) && (c == CH_NUL)) begin
				res.finished = 1'b1;
				res.status   = end_status(phase_q);
				phase_d      = PH_DONE;
			end else begin
				unique case (phase_q)
					PH_SEARCH: begin
						win.shift = 1'b1;
						if (hit) begin
							phase_d = PH_COLON;
						end
					end
					PH_COLON: begin
						if (c == CH_COLON) begin
							phase_d = PH_SPACE;
						end
					end
					PH_SPACE: begin
						if (c == CH_QUOTE) begin
							phase_d = PH_STRING;
						end else if (!is_space(c)) begin
							res.finished = 1'b1;
							res.status   = ST_NO_QUOTE;
							phase_d      = PH_DONE;
						end
					end
					PH_STRING: begin
						if (esc_q) begin
							esc_d          = 1'b0;
							res.char_valid = 1'b1;
							unique case (c)
								CH_N:    res.out_char = CH_LF;
								CH_R:    res.out_char = CH_CR;
								CH_T:    res.out_char = CH_TAB;
								default: res.out_char = c;
							endcase
						end else if (c == CH_BSL) begin
							esc_d = 1'b1;
						end else if (c == CH_QUOTE) begin
							res.finished = 1'b1;
							res.status   = ST_OK;
							phase_d      = PH_DONE;
						end else begin
							res.char_valid = 1'b1;
							res.out_char   = c;
						end
					end
					default: begin
					end
				endcase
			end
			// end of text closes an open extraction and restarts the search
			if (item.is_last) begin
				if (is_live(phase_d)) begin
					res.finished = 1'b1;
					res.status   = end_status(phase_d);
				end
				phase_d   = PH_SEARCH;
				esc_d     = 1'b0;
				win.clear = 1'b1;
			end
		end
	end

	assign res_valid = res.char_valid || res.finished;

	`JCFE_ASSERT_NEXT(a_last_restarts, clk, arst_n, step && item.is_last,
		(phase_q == PH_SEARCH) && !esc_q, "last item did not restart the search")
	`JCFE_ASSERT_IMPL(a_esc_in_string, clk, arst_n, esc_q,
		(phase_q == PH_STRING) || (phase_q == PH_DONE), "escape pending outside string")
	`JCFE_ASSERT_IMPL(a_done_silent, clk, arst_n, step && (phase_q == PH_DONE) && !item.is_last,
		!res_valid, "result produced after finishing")

endmodule

`default_nettype wire

// ===== rtl/json_content_field_extractor.sv =====
// an accepted item goes to the input register, its result then to the result register
// throughput: one item per cycle; a full result register stalls intake only when not taken
// items that give no result leave nothing in the result register
// reset: arst_n clears the phase machine, byte window, escape flag and valid bits
// the search also restarts after every item flagged last
// ----------------------------------------------------------------------------
// json_content_field_extractor
// streams out the unescaped string value of the first "content" key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_content_field_extractor import jcfe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire in_item_t item,
	output logic          result_valid,
	input  wire logic     result_ready,
	output res_item_t     result
);

	logic      item_valid_s1;
	in_item_t  item_s1;
	logic      adv;
	logic      step;
	logic      hit;
	win_ctrl_t win;
	res_item_t res;
	logic      res_valid;
	logic      result_valid_q;
	res_item_t result_q;

	assign adv        = !result_valid_q || result_ready;
	assign step       = item_valid_s1 && adv;
	assign item_ready = !item_valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	jcfe_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win),
		.in_char (item_s1.in_char),
		.hit     (hit)
	);

	jcfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.hit       (hit),
		.win       (win),
		.res       (res),
		.res_valid (res_valid)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== tb/sv/content_stream_checker.sv =====
// ----------------------------------------------------------------------------
// content_stream_checker
// watches both channels of the content field extractor, works out the result
// each accepted byte should give and compares it with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module content_stream_checker import jcfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_ready,
	input  in_item_t  item,
	input  logic      result_valid,
	input  logic      result_ready,
	input  res_item_t result,
	output int        fail_count,
	output int        pending
);

	phase_t            ph = PH_SEARCH;
	logic [71:0]       win = '0;
	logic              esc = 1'b0;
	res_item_t         expected_results[$];

	function automatic status_t abort_code(input phase_t p);
		case (p)
			PH_SEARCH: return ST_NO_KEY;
			PH_COLON:  return ST_NO_COLON;
			PH_SPACE:  return ST_NO_QUOTE;
			default:   return ST_OK;
		endcase
	endfunction

	function automatic bit extract_next(input in_item_t it, output res_item_t r);
		logic [7:0] c;
		logic [7:0] ch;
		bit         emit;
		bit         fin;
		status_t    st;
		c = it.in_char;
		ch = CH_NUL;
		emit = 1'b0;
		fin = 1'b0;
		st = ST_OK;
		if (ph != PH_DONE && c == CH_NUL) begin
			fin = 1'b1;
			st = abort_code(ph);
			ph = PH_DONE;
		end else begin
			case (ph)
				PH_SEARCH: begin
					win = {win[63:0], c};
					if (win == KEY)
						ph = PH_COLON;
				end
				PH_COLON: begin
					if (c == CH_COLON)
						ph = PH_SPACE;
				end
				PH_SPACE: begin
					if (c == CH_QUOTE) begin
						ph = PH_STRING;
					end else if (!(c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
						fin = 1'b1;
						st = ST_NO_QUOTE;
						ph = PH_DONE;
					end
				end
				PH_STRING: begin
					if (esc) begin
						esc = 1'b0;
						emit = 1'b1;
						case (c)
							CH_N:    ch = CH_LF;
							CH_R:    ch = CH_CR;
							CH_T:    ch = CH_TAB;
							default: ch = c;
						endcase
					end else if (c == CH_BSL) begin
						esc = 1'b1;
					end else if (c == CH_QUOTE) begin
						fin = 1'b1;
						st = ST_OK;
						ph = PH_DONE;
					end else begin
						emit = 1'b1;
						ch = c;
					end
				end
				default: ;
			endcase
		end
		if (it.is_last && ph != PH_DONE) begin
			fin = 1'b1;
			st = abort_code(ph);
			ph = PH_DONE;
		end
		if (it.is_last) begin
			ph = PH_SEARCH;
			win = '0;
			esc = 1'b0;
		end
		r.out_char = emit ? ch : CH_NUL;
		r.char_valid = emit;
		r.finished = fin;
		r.status = fin ? st : ST_OK;
		return emit || fin;
	endfunction

	task automatic note_error(input string what, input res_item_t e, input res_item_t g);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected char %h valid %b fin %b status %0d, got char %h valid %b fin %b status %0d",
				$realtime, what, e.out_char, e.char_valid, e.finished, e.status,
				g.out_char, g.char_valid, g.finished, g.status);
	endtask

	always @(posedge clk) begin
		res_item_t exp_res;
		res_item_t got;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				if (extract_next(item, exp_res))
					expected_results.push_back(exp_res);
			end
			if (result_valid && result_ready) begin
				got = result;
				if (expected_results.size() == 0) begin
					note_error("unexpected result", '0, got);
				end else begin
					exp_res = expected_results.pop_front();
					if (got.out_char !== exp_res.out_char || got.char_valid !== exp_res.char_valid ||
						got.finished !== exp_res.finished || got.status !== exp_res.status)
						note_error("result mismatch", exp_res, got);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// feeds byte streams into the content field extractor: a few hand-made texts
// first, then random texts, most built around the quoted key, well-formed json
// fragments mixed with broken ones; results are checked item by item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import jcfe_pkg::*;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	res_item_t result;
	int        fail_count;
	int        pending;

	int          snd_idle = 12;
	int          rcv_idle = 86;
	int          n_sent = 0;
	logic [7:0]  text_q[$];

	json_content_field_extractor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	content_stream_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] non_colon();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		return (b == CH_COLON) ? 8'h78 : b;
	endfunction

	function automatic logic [7:0] blank_byte();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SP : 8'(CH_TAB + k);
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] pick[8];
		pick = '{CH_QUOTE, 8'h63, 8'h6f, CH_N, CH_T, 8'h65, CH_COLON, CH_SP};
		if ($urandom_range(3) == 0)
			return pick[$urandom_range(7)];
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic add_content();
		logic [7:0] b;
		logic [7:0] pick[5];
		pick = '{CH_N, CH_R, CH_T, CH_QUOTE, CH_BSL};
		if ($urandom_range(9) < 3) begin
			text_q.push_back(CH_BSL);
			if ($urandom_range(5) == 5)
				text_q.push_back(8'($urandom_range(1, 255)));
			else
				text_q.push_back(pick[$urandom_range(4)]);
		end else begin
			b = 8'($urandom_range(1, 255));
			if (b == CH_QUOTE || b == CH_BSL)
				b = 8'h61;
			text_q.push_back(b);
		end
	endtask

	task automatic build_text();
		int         kind;
		int         ending;
		logic [7:0] b;
		text_q.delete();
		kind = $urandom_range(99);
		repeat ($urandom_range(4)) text_q.push_back(noise_byte());
		if (kind < 8) begin
			repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(255)));
			return;
		end
		if (kind < 12)
			push_str("\"conte");
		push_str("\"content\"");
		if (kind < 18) begin
			repeat ($urandom_range(3)) text_q.push_back(non_colon());
			if ($urandom_range(1))
				text_q.push_back(CH_NUL);
			return;
		end
		repeat ($urandom_range(2)) text_q.push_back(non_colon());
		text_q.push_back(CH_COLON);
		repeat ($urandom_range(3)) text_q.push_back(blank_byte());
		if (kind < 26) begin
			b = 8'($urandom_range(255));
			if (b == CH_QUOTE || b == CH_SP || (b >= CH_TAB && b <= CH_CR))
				b = 8'h78;
			text_q.push_back(b);
			repeat ($urandom_range(2)) text_q.push_back(8'($urandom_range(255)));
			return;
		end
		text_q.push_back(CH_QUOTE);
		repeat ($urandom_range(8)) add_content();
		ending = $urandom_range(9);
		if (ending <= 4) begin
			text_q.push_back(CH_QUOTE);
			repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
		end else if (ending == 7) begin
			text_q.push_back(CH_BSL);
		end else if (ending == 8) begin
			text_q.push_back(CH_BSL);
			text_q.push_back(CH_NUL);
		end else if (ending == 9) begin
			text_q.push_back(CH_NUL);
			repeat ($urandom_range(2)) text_q.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < snd_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{in_char: c, is_last: last};
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	initial begin
		int guard;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero byte while searching, then a byte after the finish
		text_q = '{CH_NUL, 8'hff};
		send_text();
		// last flag while searching
		text_q = '{8'h78};
		send_text();
		// escapes, then a zero byte dropping a pending escape
		text_q.delete();
		push_str("\"content\": \"\\n\\x\\");
		text_q.push_back(CH_NUL);
		send_text();

		while (n_sent < 550) begin
			if (n_sent >= 370) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (n_sent >= 180) begin
				snd_idle = 86;
				rcv_idle = 12;
			end
			build_text();
			send_text();
		end
		item_valid <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jcfe_pkg.sv
rtl/jcfe_window.sv
rtl/jcfe_ctrl.sv
rtl/json_content_field_extractor.sv
tb/sv/content_stream_checker.sv
tb/sv/testbench.sv
